// File: src/srf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srf_pkg
// Shared constants and types of the syscall restriction filter.
// ----------------------------------------------------------------------------
package srf_pkg;

   localparam int RULE_DEPTH = 32;
   localparam int RULE_AW    = $clog2(RULE_DEPTH);
   localparam int RULE_CNT_W = 6;

   localparam int LOG_DEPTH  = 128;
   localparam int LOG_AW     = $clog2(LOG_DEPTH);
   localparam int LOG_FILL_W = $clog2(LOG_DEPTH + 1);

   localparam int KIND_W  = 2;
   localparam int RIDX_W  = 5;
   localparam int SYS_W   = 10;
   localparam int THR_W   = 2;
   localparam int LVL_W   = 2;
   localparam int TIME_W  = 32;
   localparam int AGE_W   = 7;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 6;

   // item kinds
   localparam logic [KIND_W-1:0] KIND_RULE_WR = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CHECK   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_LOG_RD  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RULE_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EXEMPT     = 2'd2;

   typedef struct packed {
      logic [SYS_W-1:0] number;
      logic [THR_W-1:0] threshold;
   } rule_entry_type;

   typedef struct packed {
      logic [SYS_W-1:0]  sys;
      logic [THR_W-1:0]  thr;
      logic [LVL_W-1:0]  lvl;
      logic [TIME_W-1:0] stamp;
   } log_entry_type;

   typedef struct packed {
      logic             push;
      logic             read;
      logic [AGE_W-1:0] age;
   } log_cmd_type;

   typedef struct packed {
      logic [LOG_FILL_W-1:0] fill;
      logic [LOG_FILL_W-1:0] fill_after_push;
   } log_stat_type;

endpackage

// File: src/syscall_restriction_filter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// syscall_restriction_filter_top
// Syscall access filter: first-match rule scan with a ring log of denials.
// ----------------------------------------------------------------------------
//
//  channel  | handshake             | beat contents
//  ---------+-----------------------+------------------------------------------
//  request  | start & !busy         | req_kind, rule index/threshold, syscall,
//           |                       | time stamp, log age
//  response | rsp_strobe (1 cycle)  | denied, fill, log read valid and data
//  csr      | csr_valid & csr_ready | csr_index, csr_wdata (ready always high)
//
// Rule write and unused kind answer in the cycle after accept; a log read
// below the fill passes through ST_LOG_RD (one memory read) before it
// answers, and one at or past the fill answers in the cycle after accept.
// A check reads the rule memory one entry per cycle, pipelined against the
// compare, up to RULE_DEPTH (32) entries, and answers the cycle after the last.
// An exempt process or an empty rule table answers in the cycle after accept.
// Reset (synchronous) clears the configuration, state, strobe and scan
// index registers, log head and fill count; the rule and log memories are
// not cleared and need no sweep. The response strobe lasts one cycle and
// cannot be stalled; a new request is taken in the same cycle as the strobe.
//
module syscall_restriction_filter_top (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              start,
   output logic                              busy,
   input  logic [srf_pkg::KIND_W-1:0]        req_kind,
   input  logic [srf_pkg::RIDX_W-1:0]        req_rule_index,
   input  logic [srf_pkg::SYS_W-1:0]         req_syscall_id,
   input  logic [srf_pkg::THR_W-1:0]         req_rule_threshold,
   input  logic [srf_pkg::TIME_W-1:0]        req_time_stamp,
   input  logic [srf_pkg::AGE_W-1:0]         req_log_age,

   output logic                              rsp_strobe,
   output logic                              rsp_denied,
   output logic [srf_pkg::LOG_FILL_W-1:0]    rsp_log_fill,
   output logic                              rsp_log_valid,
   output logic [srf_pkg::SYS_W-1:0]         rsp_log_syscall,
   output logic [srf_pkg::THR_W-1:0]         rsp_log_threshold,
   output logic [srf_pkg::LVL_W-1:0]         rsp_log_level,
   output logic [srf_pkg::TIME_W-1:0]        rsp_log_time,

   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [srf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [srf_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LOG_RD
   } state_type;

   localparam logic [srf_pkg::RULE_CNT_W-1:0] RULE_MAX =
      srf_pkg::RULE_CNT_W'(srf_pkg::RULE_DEPTH);

   state_type state_ff;

   // configuration
   logic [srf_pkg::LVL_W-1:0]      level_ff;
   logic [srf_pkg::RULE_CNT_W-1:0] rule_count_ff;
   logic                           exempt_ff;

   // captured check item
   logic [srf_pkg::SYS_W-1:0]      sys_ff;
   logic [srf_pkg::TIME_W-1:0]     stamp_ff;
   logic [srf_pkg::RULE_AW-1:0]    scan_idx_ff;

   // response registers
   logic                           rsp_strobe_ff;
   logic                           rsp_denied_ff;
   logic [srf_pkg::LOG_FILL_W-1:0] rsp_fill_ff;
   logic                           rsp_valid_ff;
   srf_pkg::log_entry_type         rsp_entry_ff;

   logic                           accept;
   logic [srf_pkg::RULE_CNT_W-1:0] scan_limit;
   logic                           scan_last;
   logic                           rule_hit;
   logic                           rule_deny;
   logic                           age_ok;

   logic                           rule_wr_en;
   logic                           rule_rd_en;
   logic [srf_pkg::RULE_AW-1:0]    rule_rd_addr;
   srf_pkg::rule_entry_type        rule_wr_data;
   srf_pkg::rule_entry_type        rule_rd_data;

   srf_pkg::log_cmd_type           log_cmd;
   srf_pkg::log_stat_type          log_stat;
   srf_pkg::log_entry_type         log_wr_data;
   srf_pkg::log_entry_type         log_rd_data;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   // scan stops at the table depth
   assign scan_limit = (rule_count_ff > RULE_MAX) ? RULE_MAX : rule_count_ff;
   assign scan_last  = (srf_pkg::RULE_CNT_W'(scan_idx_ff) + 1'b1) == scan_limit;
   assign rule_hit   = (rule_rd_data.number == sys_ff);
   assign rule_deny  = rule_hit && (level_ff < rule_rd_data.threshold);
   assign age_ok     = (srf_pkg::LOG_FILL_W'(req_log_age) < log_stat.fill);

   // rule memory ports
   assign rule_wr_en   = accept && (req_kind == srf_pkg::KIND_RULE_WR)
                      && (32'(req_rule_index) < srf_pkg::RULE_DEPTH);
   assign rule_wr_data = '{number: req_syscall_id, threshold: req_rule_threshold};
   assign rule_rd_en   = (accept && (req_kind == srf_pkg::KIND_CHECK))
                      || ((state_ff == ST_SCAN) && !rule_hit && !scan_last);
   assign rule_rd_addr = accept ? '0 : scan_idx_ff + 1'b1;

   // log ports
   assign log_cmd.push = (state_ff == ST_SCAN) && rule_deny;
   assign log_cmd.read = accept && (req_kind == srf_pkg::KIND_LOG_RD) && age_ok;
   assign log_cmd.age  = req_log_age;
   assign log_wr_data  = '{sys: sys_ff, thr: rule_rd_data.threshold,
                           lvl: level_ff, stamp: stamp_ff};

   srf_rule_table u_rules (
      .clock   (clock),
      .wr_en   (rule_wr_en),
      .wr_addr (req_rule_index[srf_pkg::RULE_AW-1:0]),
      .wr_data (rule_wr_data),
      .rd_en   (rule_rd_en),
      .rd_addr (rule_rd_addr),
      .rd_data (rule_rd_data)
   );

   srf_violation_log u_log (
      .clock   (clock),
      .reset   (reset),
      .cmd     (log_cmd),
      .wr_data (log_wr_data),
      .stat    (log_stat),
      .rd_data (log_rd_data)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff      <= '0;
         rule_count_ff <= '0;
         exempt_ff     <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            srf_pkg::CSR_LEVEL:      level_ff      <= csr_wdata[srf_pkg::LVL_W-1:0];
            srf_pkg::CSR_RULE_COUNT: rule_count_ff <= csr_wdata;
            srf_pkg::CSR_EXEMPT:     exempt_ff     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // item capture
   always_ff @(posedge clock) begin
      if (accept) begin
         sys_ff   <= req_syscall_id;
         stamp_ff <= req_time_stamp;
      end
   end

   // sequencer and response registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
         scan_idx_ff   <= '0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  rsp_denied_ff <= 1'b0;
                  rsp_valid_ff  <= 1'b0;
                  rsp_entry_ff  <= '0;
                  rsp_fill_ff   <= log_stat.fill;
                  scan_idx_ff   <= '0;
                  unique case (req_kind)
                     srf_pkg::KIND_CHECK: begin
                        if (exempt_ff || (scan_limit == '0)) begin
                           rsp_strobe_ff <= 1'b1;
                        end else begin
                           state_ff <= ST_SCAN;
                        end
                     end
                     srf_pkg::KIND_LOG_RD: begin
                        if (age_ok) begin
                           state_ff <= ST_LOG_RD;
                        end else begin
                           rsp_strobe_ff <= 1'b1;
                        end
                     end
                     default: begin
                        rsp_strobe_ff <= 1'b1;
                     end
                  endcase
               end
            end
            ST_SCAN: begin
               if (rule_hit || scan_last) begin
                  state_ff      <= ST_IDLE;
                  rsp_strobe_ff <= 1'b1;
                  rsp_denied_ff <= rule_deny;
                  rsp_fill_ff   <= rule_deny ? log_stat.fill_after_push : log_stat.fill;
               end else begin
                  scan_idx_ff <= scan_idx_ff + 1'b1;
               end
            end
            ST_LOG_RD: begin
               state_ff      <= ST_IDLE;
               rsp_strobe_ff <= 1'b1;
               rsp_valid_ff  <= 1'b1;
               rsp_entry_ff  <= log_rd_data;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_denied        = rsp_denied_ff;
   assign rsp_log_fill      = rsp_fill_ff;
   assign rsp_log_valid     = rsp_valid_ff;
   assign rsp_log_syscall   = rsp_entry_ff.sys;
   assign rsp_log_threshold = rsp_entry_ff.thr;
   assign rsp_log_level     = rsp_entry_ff.lvl;
   assign rsp_log_time      = rsp_entry_ff.stamp;

endmodule

// File: src/srf_rule_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srf_rule_table
// Rule memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module srf_rule_table (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [srf_pkg::RULE_AW-1:0]    wr_addr,
   input  srf_pkg::rule_entry_type        wr_data,
   input  logic                           rd_en,
   input  logic [srf_pkg::RULE_AW-1:0]    rd_addr,
   output srf_pkg::rule_entry_type        rd_data
);

   srf_pkg::rule_entry_type mem [srf_pkg::RULE_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// File: src/srf_violation_log.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srf_violation_log
// Ring log of denied checks, newest at head; read by age, fill saturates.
// ----------------------------------------------------------------------------
module srf_violation_log (
   input  logic                    clock,
   input  logic                    reset,
   input  srf_pkg::log_cmd_type    cmd,
   input  srf_pkg::log_entry_type  wr_data,
   output srf_pkg::log_stat_type   stat,
   output srf_pkg::log_entry_type  rd_data
);

   localparam logic [srf_pkg::LOG_AW-1:0] HEAD_LAST =
      srf_pkg::LOG_AW'(srf_pkg::LOG_DEPTH - 1);
   localparam logic [srf_pkg::LOG_FILL_W-1:0] FILL_MAX =
      srf_pkg::LOG_FILL_W'(srf_pkg::LOG_DEPTH);

   srf_pkg::log_entry_type mem [srf_pkg::LOG_DEPTH];

   logic [srf_pkg::LOG_AW-1:0]     head_ff, head_in;
   logic [srf_pkg::LOG_FILL_W-1:0] fill_ff, fill_in;
   logic [srf_pkg::LOG_AW-1:0]     push_slot;
   logic [srf_pkg::LOG_AW-1:0]     rd_slot;
   logic [srf_pkg::LOG_AW:0]       wrap_sum;

   // first push goes to slot 0 without advancing
   always_comb begin
      if (fill_ff != '0) begin
         push_slot = (head_ff == HEAD_LAST) ? '0 : head_ff + 1'b1;
      end else begin
         push_slot = head_ff;
      end
   end

   assign stat.fill            = fill_ff;
   assign stat.fill_after_push = (fill_ff == FILL_MAX) ? fill_ff : fill_ff + 1'b1;

   always_comb begin
      head_in = head_ff;
      fill_in = fill_ff;
      if (cmd.push) begin
         head_in = push_slot;
         fill_in = stat.fill_after_push;
      end
   end

   // age to slot, wrapping below slot 0
   assign wrap_sum = {1'b0, head_ff} + (srf_pkg::LOG_AW+1)'(srf_pkg::LOG_DEPTH)
                   - (srf_pkg::LOG_AW+1)'(cmd.age);
   assign rd_slot  = ((srf_pkg::LOG_AW+1)'(cmd.age) <= {1'b0, head_ff}) ?
                     head_ff - srf_pkg::LOG_AW'(cmd.age) : wrap_sum[srf_pkg::LOG_AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[push_slot] <= wr_data;
      end
      if (cmd.read) begin
         rd_data <= mem[rd_slot];
      end
   end

endmodule
